>>> hw/rtl/wdf_pkg.sv
// ----------------------------------------------------------------------------
// wdf_pkg
// Shared constants, types and helpers for the wet/dry face flux pipeline.
// ----------------------------------------------------------------------------
package wdf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QW            = 31;
    localparam logic [QW-1:0] QMAX = {QW{1'b1}};

    localparam int DIV_LAT  = QW + 1;
    localparam int FACE_LAT = 2 * DIV_LAT + 7;

    localparam int CIW = 2;
    localparam logic [CIW-1:0] CFG_GRAVITY   = 2'd0;
    localparam logic [CIW-1:0] CFG_DRY_DEPTH = 2'd1;
    localparam logic [CIW-1:0] CFG_CELL_SIZE = 2'd2;
    localparam logic [CIW-1:0] CFG_TIME_STEP = 2'd3;

    localparam logic [QW-1:0] GRAVITY_RST   = 31'd642908;
    localparam logic [QW-1:0] DRY_DEPTH_RST = 31'd7;
    localparam logic [QW-1:0] CELL_SIZE_RST = 31'd131072;
    localparam logic [QW-1:0] TIME_STEP_RST = 31'd65536;

    typedef struct packed {
        logic [QW-1:0] gravity;
        logic [QW-1:0] dry_depth;
        logic [QW-1:0] cell_size;
        logic [QW-1:0] time_step;
    } t_cfg;

    typedef struct packed {
        logic               ritter;
        logic [QW-1:0]      vol;
        logic signed [31:0] mass;
        logic [QW-1:0]      mom;
    } t_face_res;

    function automatic int sqrt_lat(input int f);
        return (32 + f) / 2;
    endfunction

    function automatic logic [QW-1:0] depth_of(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        if (d[32]) begin
            return '0;
        end else if (d[31]) begin
            return QMAX;
        end
        return d[QW-1:0];
    endfunction

    function automatic logic signed [31:0] floor_mean(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        return s[32:1];
    endfunction

endpackage

>>> hw/rtl/wdf_delay.sv
// ----------------------------------------------------------------------------
// wdf_delay
// Fixed-length shift line that keeps side values aligned with the pipeline.
// ----------------------------------------------------------------------------
module wdf_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    generate
        if (N == 0) begin : g_none
            assign o_q = i_d;
        end else begin : g_sr
            logic [W-1:0] r_sr [N];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sr[0] <= i_d;
                    for (int k = 1; k < N; k++) begin
                        r_sr[k] <= r_sr[k-1];
                    end
                end
            end
            assign o_q = r_sr[N-1];
        end
    endgenerate

endmodule

>>> hw/rtl/wdf_mul.sv
// ----------------------------------------------------------------------------
// wdf_mul
// Registered saturating fixed-point multiply of two unsigned magnitudes.
// ----------------------------------------------------------------------------
module wdf_mul #(
    parameter int FRAC_BITS = wdf_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [wdf_pkg::QW-1:0] i_a,
    input  logic [wdf_pkg::QW-1:0] i_b,
    output logic [wdf_pkg::QW-1:0] o_p
);
    import wdf_pkg::*;

    logic [2*QW-1:0] w_prod;
    logic [2*QW-1:0] w_sh;
    logic [QW-1:0]   r_p;

    assign w_prod = (2*QW)'(i_a) * (2*QW)'(i_b);
    assign w_sh   = w_prod >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= (|w_sh[2*QW-1:QW]) ? QMAX : w_sh[QW-1:0];
        end
    end

    assign o_p = r_p;

endmodule

>>> hw/rtl/wdf_sqrt.sv
// ----------------------------------------------------------------------------
// wdf_sqrt
// Pipelined restoring square root of x << FRAC_BITS, one root bit a stage.
// ----------------------------------------------------------------------------
module wdf_sqrt #(
    parameter int FRAC_BITS = wdf_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [wdf_pkg::QW-1:0] i_x,
    output logic [wdf_pkg::QW-1:0] o_root
);
    import wdf_pkg::*;

    localparam int RW = sqrt_lat(FRAC_BITS);

    logic [RW+1:0]   r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [2*RW-1:0] r_rad  [RW];

    genvar k;
    generate
        for (k = 0; k < RW; k++) begin : g_stage
            logic [RW+1:0]   w_rem_prev;
            logic [RW-1:0]   w_root_prev;
            logic [2*RW-1:0] w_rad_prev;
            logic [RW+1:0]   w_acc;
            logic [RW+1:0]   w_trial;
            logic            w_ge;

            if (k == 0) begin : g_first
                assign w_rem_prev  = '0;
                assign w_root_prev = '0;
                assign w_rad_prev  = (2*RW)'({i_x, {FRAC_BITS{1'b0}}});
            end else begin : g_next
                assign w_rem_prev  = r_rem[k-1];
                assign w_root_prev = r_root[k-1];
                assign w_rad_prev  = r_rad[k-1];
            end

            assign w_acc   = {w_rem_prev[RW-1:0], w_rad_prev[2*RW-1 -: 2]};
            assign w_trial = {w_root_prev, 2'b01};
            assign w_ge    = (w_acc >= w_trial);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= w_ge ? (w_acc - w_trial) : w_acc;
                    r_root[k] <= {w_root_prev[RW-2:0], w_ge};
                    r_rad[k]  <= w_rad_prev << 2;
                end
            end
        end
    endgenerate

    assign o_root = QW'(r_root[RW-1]);

endmodule

>>> hw/rtl/wdf_div.sv
// ----------------------------------------------------------------------------
// wdf_div
// Pipelined saturating quotient (a << FRAC_BITS) / b, one bit a stage.
// ----------------------------------------------------------------------------
module wdf_div #(
    parameter int FRAC_BITS = wdf_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [wdf_pkg::QW-1:0] i_a,
    input  logic [wdf_pkg::QW-1:0] i_b,
    output logic [wdf_pkg::QW-1:0] o_q
);
    import wdf_pkg::*;

    localparam int NW = 2 * QW;

    logic [NW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_b   [QW+1];
    logic [QW-1:0] r_q   [QW+1];
    logic          r_sat [QW+1];

    logic [NW-1:0] w_num;

    assign w_num = NW'(i_a) << FRAC_BITS;

    // overflow of the top quotient bits is known up front
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_num;
            r_b[0]   <= i_b;
            r_q[0]   <= '0;
            r_sat[0] <= (i_b == '0) || (w_num >= {i_b, {QW{1'b0}}});
        end
    end

    genvar s;
    generate
        for (s = 1; s <= QW; s++) begin : g_stage
            logic [NW-1:0] w_trial;
            logic          w_ge;

            assign w_trial = NW'(r_b[s-1]) << (QW - s);
            assign w_ge    = (r_rem[s-1] >= w_trial);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= w_ge ? (r_rem[s-1] - w_trial) : r_rem[s-1];
                    r_b[s]   <= r_b[s-1];
                    r_q[s]   <= {r_q[s-1][QW-2:0], w_ge};
                    r_sat[s] <= r_sat[s-1];
                end
            end
        end
    endgenerate

    assign o_q = r_sat[QW] ? QMAX : r_q[QW];

endmodule

>>> hw/rtl/wdf_face.sv
// ----------------------------------------------------------------------------
// wdf_face
// Flux across the face shared with one neighbour: pressure or Ritter inflow.
// ----------------------------------------------------------------------------
module wdf_face #(
    parameter int FRAC_BITS = wdf_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  wdf_pkg::t_cfg      i_cfg,
    input  logic signed [31:0] i_bed_here,
    input  logic signed [31:0] i_bed_nb,
    input  logic signed [31:0] i_surf_here,
    input  logic signed [31:0] i_surf_nb,
    output wdf_pkg::t_face_res o_res
);
    import wdf_pkg::*;

    localparam int LS = sqrt_lat(FRAC_BITS);
    localparam logic [QW-1:0] C0296 = QW'(((64'd296 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [QW-1:0] C0444 = QW'(((64'd444 << FRAC_BITS) + 64'd500) / 64'd1000);

    logic signed [31:0] r1_fb;
    logic signed [31:0] r1_znb;
    logic [QW-1:0]      r1_d0, r1_dnb;
    logic               r1_hyd;
    logic [QW-1:0]      r2_hm, r2_d0, r2_dnb;
    logic               r2_hyd;
    logic [QW-1:0]      r3_hm, r3_d, r3_dnb;
    logic               r3_wet, r3_hyd;
    logic [QW-1:0]      r4_hm, r5_hf;
    logic [QW-1:0]      r_m, r_m70;
    t_face_res          r_res;

    logic [QW-1:0] w_p1, w_m1, w_m2, w_hf, w_v1;
    logic [QW-1:0] w_p2, w_ph, w_phf, w_sq, w_m1d, w_q, w_qd, w_v;
    logic [QW-1:0] w_hf37, w_u, w_m69, w_mu, w_v70, w_p2_70, w_phf70, w_u_sel;
    logic          w_hfz69, w_wet70, w_hyd70;
    logic [31:0]   w_sum;
    logic [QW-1:0] w_mom_r;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_fb  <= floor_mean(i_bed_nb, i_bed_here);
            r1_znb <= i_surf_nb;
            r1_d0  <= depth_of(i_surf_nb, i_surf_here);
            r1_dnb <= depth_of(i_surf_nb, i_bed_nb);
            r1_hyd <= (i_surf_nb <= i_surf_here);
            r2_hm  <= depth_of(r1_znb, r1_fb);
            r2_d0  <= r1_d0;
            r2_dnb <= r1_dnb;
            r2_hyd <= r1_hyd;
            r3_wet <= (r2_hm > i_cfg.dry_depth);
            r3_d   <= (r2_d0 > r2_hm) ? r2_hm : r2_d0;
            r3_hm  <= r2_hm;
            r3_dnb <= r2_dnb;
            r3_hyd <= r2_hyd;
            r4_hm  <= r3_hm;
            r5_hf  <= w_hf;
        end
    end

    wdf_mul #(.FRAC_BITS(FRAC_BITS)) u_p1 (.i_clk, .i_en, .i_a(i_cfg.gravity), .i_b(r3_hm),
                                           .o_p(w_p1));
    wdf_mul #(.FRAC_BITS(FRAC_BITS)) u_m1 (.i_clk, .i_en, .i_a(C0296), .i_b(r3_d), .o_p(w_m1));
    wdf_mul #(.FRAC_BITS(FRAC_BITS)) u_m2 (.i_clk, .i_en, .i_a(i_cfg.gravity), .i_b(r3_d),
                                           .o_p(w_m2));
    wdf_mul #(.FRAC_BITS(FRAC_BITS)) u_hf (.i_clk, .i_en, .i_a(C0444), .i_b(r3_d), .o_p(w_hf));
    wdf_mul #(.FRAC_BITS(FRAC_BITS)) u_v1 (.i_clk, .i_en, .i_a(i_cfg.cell_size), .i_b(r3_dnb),
                                           .o_p(w_v1));

    wdf_mul #(.FRAC_BITS(FRAC_BITS)) u_p2 (.i_clk, .i_en, .i_a(w_p1), .i_b(r4_hm), .o_p(w_p2));
    wdf_mul #(.FRAC_BITS(FRAC_BITS)) u_ph (.i_clk, .i_en, .i_a(i_cfg.gravity), .i_b(w_hf),
                                           .o_p(w_ph));
    wdf_mul #(.FRAC_BITS(FRAC_BITS)) u_phf (.i_clk, .i_en, .i_a(w_ph), .i_b(r5_hf),
                                            .o_p(w_phf));

    wdf_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sq (.i_clk, .i_en, .i_x(w_m2), .o_root(w_sq));
    wdf_delay #(.W(QW), .N(LS)) u_dm1 (.i_clk, .i_en, .i_d(w_m1), .o_q(w_m1d));
    wdf_mul #(.FRAC_BITS(FRAC_BITS)) u_q (.i_clk, .i_en, .i_a(w_m1d), .i_b(w_sq), .o_p(w_q));
    wdf_delay #(.W(QW), .N(DIV_LAT - LS - 1)) u_dq (.i_clk, .i_en, .i_d(w_q), .o_q(w_qd));

    wdf_div #(.FRAC_BITS(FRAC_BITS)) u_vol (.i_clk, .i_en, .i_a(w_v1), .i_b(i_cfg.time_step),
                                            .o_q(w_v));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m   <= (w_qd < w_v) ? w_qd : w_v;
            r_m70 <= w_m69;
        end
    end

    wdf_delay #(.W(QW), .N(DIV_LAT + 1)) u_dhf (.i_clk, .i_en, .i_d(w_hf), .o_q(w_hf37));
    wdf_div #(.FRAC_BITS(FRAC_BITS)) u_vel (.i_clk, .i_en, .i_a(r_m), .i_b(w_hf37), .o_q(w_u));
    wdf_delay #(.W(1), .N(DIV_LAT)) u_dhz (.i_clk, .i_en, .i_d(w_hf37 == '0), .o_q(w_hfz69));
    wdf_delay #(.W(QW), .N(DIV_LAT)) u_dm (.i_clk, .i_en, .i_d(r_m), .o_q(w_m69));

    // shallow face: velocity taken as zero
    assign w_u_sel = w_hfz69 ? '0 : w_u;
    wdf_mul #(.FRAC_BITS(FRAC_BITS)) u_mu (.i_clk, .i_en, .i_a(w_m69), .i_b(w_u_sel),
                                           .o_p(w_mu));

    wdf_delay #(.W(QW), .N(DIV_LAT + 2)) u_dv (.i_clk, .i_en, .i_d(w_v), .o_q(w_v70));
    wdf_delay #(.W(QW), .N(2 * DIV_LAT + 1)) u_dp2 (.i_clk, .i_en, .i_d(w_p2), .o_q(w_p2_70));
    wdf_delay #(.W(QW), .N(2 * DIV_LAT)) u_dphf (.i_clk, .i_en, .i_d(w_phf), .o_q(w_phf70));
    wdf_delay #(.W(2), .N(2 * DIV_LAT + 3)) u_dfl (.i_clk, .i_en, .i_d({r3_wet, r3_hyd}),
                                                   .o_q({w_wet70, w_hyd70}));

    assign w_sum   = 32'(w_mu) + 32'(w_phf70 >> 1);
    assign w_mom_r = w_sum[31] ? QMAX : w_sum[QW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.ritter <= w_wet70 & ~w_hyd70;
            r_res.vol    <= w_v70;
            r_res.mass   <= (w_wet70 & ~w_hyd70) ? -$signed({1'b0, r_m70}) : '0;
            r_res.mom    <= !w_wet70 ? '0 : (w_hyd70 ? (w_p2_70 >> 1) : w_mom_r);
        end
    end

    assign o_res = r_res;

endmodule

>>> hw/rtl/wet_dry_face_flux.sv
// ----------------------------------------------------------------------------
// wet_dry_face_flux
// East and north face fluxes of one grid cell with wetting and drying.
// ----------------------------------------------------------------------------
// Input items arrive on s_axis: tuser carries the dry flags and edge flags,
// tdata the bed and surface elevations of the cell and its east and north
// neighbours. Each item gives exactly one result item on m_axis: six face
// fluxes in tdata and the all-dry flag in tuser.
// Configuration (gravity, dry depth, cell size, time step) is written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it only while no item
// is in flight, which the block itself does not enforce. One item is taken
// every cycle while m_axis is not stalled. The two 32-stage dividers (volume
// rate, then face velocity) in series set the depth.
// Synchronous reset empties the pipeline and loads the default configuration.
// The pipeline moves as a whole: while the output item waits on
// m_axis_tready, every stage holds and s_axis_tready is low; nothing in
// flight is lost or repeated.
// ----------------------------------------------------------------------------
module wet_dry_face_flux #(
    parameter int FRAC_BITS = wdf_pkg::FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // bed_here, bed_east, bed_north, surface_here, surface_east, surface_north
    input  logic [191:0]             s_axis_tdata,
    // dry_mask[4:0], on_row_edge, on_col_edge, zero pad
    input  logic [7:0]               s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // east_mass, east_mom_x, east_mom_y, north_mass, north_mom_x, north_mom_y
    output logic [191:0]             m_axis_tdata,
    // all_dry, zero pad
    output logic [7:0]               m_axis_tuser,
    input  logic                     i_cfg_we,
    input  logic [wdf_pkg::CIW-1:0]  i_cfg_idx,
    input  logic [wdf_pkg::QW-1:0]   i_cfg_data
);
    import wdf_pkg::*;

    localparam int LS = sqrt_lat(FRAC_BITS);

    logic               w_en;
    t_cfg               r_cfg;
    logic               r0_v;
    logic [4:0]         r0_mask;
    logic               r0_row, r0_col;
    logic signed [31:0] r0_bh, r0_be, r0_bn, r0_sh, r0_se, r0_sn;
    logic [FACE_LAT:1]  r_vld;
    logic               r_out_valid;
    logic [191:0]       r_out_data;
    logic [7:0]         r_out_user;
    logic [QW-1:0]      r1_hp, r1_g, r_sqg;

    t_face_res          w_east, w_north;
    logic [QW-1:0]      w_sqh, w_sqg, w_hpd, w_w1, w_w2, w_weir;
    logic [4:0]         w_mask;
    logic               w_row, w_col;
    logic               w_e_run, w_n_run, w_alldry;
    logic [QW-1:0]      w_vol, w_wc;
    logic signed [31:0] w_e_mass, w_n_mass;
    logic [QW-1:0]      w_e_mom, w_n_mom;

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gravity   <= GRAVITY_RST;
            r_cfg.dry_depth <= DRY_DEPTH_RST;
            r_cfg.cell_size <= CELL_SIZE_RST;
            r_cfg.time_step <= TIME_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRAVITY:   r_cfg.gravity   <= i_cfg_data;
                CFG_DRY_DEPTH: r_cfg.dry_depth <= i_cfg_data;
                CFG_CELL_SIZE: r_cfg.cell_size <= i_cfg_data;
                CFG_TIME_STEP: r_cfg.time_step <= i_cfg_data;
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v        <= 1'b0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r0_v        <= s_axis_tvalid;
            r_vld       <= {r_vld[FACE_LAT-1:1], r0_v};
            r_out_valid <= r_vld[FACE_LAT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_mask <= s_axis_tuser[4:0];
            r0_row  <= s_axis_tuser[5];
            r0_col  <= s_axis_tuser[6];
            r0_bh   <= s_axis_tdata[31:0];
            r0_be   <= s_axis_tdata[63:32];
            r0_bn   <= s_axis_tdata[95:64];
            r0_sh   <= s_axis_tdata[127:96];
            r0_se   <= s_axis_tdata[159:128];
            r0_sn   <= s_axis_tdata[191:160];
            r1_hp   <= depth_of(r0_sh, r0_bh);
            r1_g    <= r_cfg.gravity;
            r_sqg   <= w_sqg;
        end
    end

    wdf_face #(.FRAC_BITS(FRAC_BITS)) u_east (
        .i_clk, .i_en(w_en), .i_cfg(r_cfg),
        .i_bed_here(r0_bh), .i_bed_nb(r0_be), .i_surf_here(r0_sh), .i_surf_nb(r0_se),
        .o_res(w_east)
    );

    wdf_face #(.FRAC_BITS(FRAC_BITS)) u_north (
        .i_clk, .i_en(w_en), .i_cfg(r_cfg),
        .i_bed_here(r0_bh), .i_bed_nb(r0_bn), .i_surf_here(r0_sh), .i_surf_nb(r0_sn),
        .o_res(w_north)
    );

    // weir discharge of this cell
    wdf_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqh (.i_clk, .i_en(w_en), .i_x(r1_hp), .o_root(w_sqh));
    wdf_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqg (.i_clk, .i_en(w_en), .i_x(r1_g), .o_root(w_sqg));
    wdf_delay #(.W(QW), .N(LS)) u_dhp (.i_clk, .i_en(w_en), .i_d(r1_hp), .o_q(w_hpd));
    wdf_mul #(.FRAC_BITS(FRAC_BITS)) u_w1 (.i_clk, .i_en(w_en), .i_a(w_hpd), .i_b(w_sqh),
                                           .o_p(w_w1));
    wdf_mul #(.FRAC_BITS(FRAC_BITS)) u_w2 (.i_clk, .i_en(w_en), .i_a(r_sqg), .i_b(w_w1),
                                           .o_p(w_w2));
    wdf_delay #(.W(QW), .N(FACE_LAT - 3 - LS)) u_dw (.i_clk, .i_en(w_en), .i_d(w_w2),
                                                     .o_q(w_weir));

    wdf_delay #(.W(7), .N(FACE_LAT)) u_dflg (
        .i_clk, .i_en(w_en), .i_d({r0_col, r0_row, r0_mask}), .o_q({w_col, w_row, w_mask})
    );

    always_comb begin
        w_alldry = (w_mask == 5'h1F);
        w_e_run  = !w_mask[2] && w_east.ritter;
        w_n_run  = !w_mask[4] && w_north.ritter;
        w_vol    = w_n_run ? w_north.vol : w_east.vol;
        w_wc     = ((w_e_run || w_n_run) && (w_vol < w_weir)) ? w_vol : w_weir;
        w_e_mass = w_row ? $signed({1'b0, w_wc}) : (!w_mask[2] ? w_east.mass : '0);
        w_n_mass = w_col ? $signed({1'b0, w_wc}) : (!w_mask[4] ? w_north.mass : '0);
        w_e_mom  = !w_mask[2] ? w_east.mom : '0;
        w_n_mom  = !w_mask[4] ? w_north.mom : '0;
        if (w_alldry) begin
            w_e_mass = '0;
            w_n_mass = '0;
            w_e_mom  = '0;
            w_n_mom  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= {1'b0, w_n_mom, 32'd0, w_n_mass,
                           32'd0, 1'b0, w_e_mom, w_e_mass};
            r_out_user <= {7'd0, w_alldry};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_dry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("all-dry item with non-zero flux");

    a_tang_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[95:64] == '0 && m_axis_tdata[159:128] == '0)
        else $error("tangential momentum not zero");

    a_inflow_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[FACE_LAT] && !w_row |-> w_e_mass <= 0)
        else $error("east mass outflow without weir");

endmodule
